// ===== src/lfrb_pkg.sv =====
// Shared types and constants of the local flow record batcher.
// Depends on nothing; every file but lfrb_ram imports it.
`default_nettype none

package lfrb_pkg;

	localparam int BATCH_DEPTH = 64;
	localparam int ADDR_W      = (BATCH_DEPTH > 1) ? $clog2(BATCH_DEPTH) : 1;
	localparam int CNT_W       = ADDR_W + 1;

	localparam logic [15:0] ETHER_IPV4    = 16'h0800;
	localparam logic [7:0]  PROTO_TCP     = 8'd6;
	localparam logic [7:0]  PROTO_UDP     = 8'd17;
	localparam logic [15:0] FLUSH_IVL_RST = 16'd41;

	localparam logic OP_PACKET = 1'b0;
	localparam logic OP_TICK   = 1'b1;

	localparam logic [1:0] KIND_TCP   = 2'd0;
	localparam logic [1:0] KIND_UDP   = 2'd1;
	localparam logic [1:0] KIND_OTHER = 2'd2;

	localparam logic [1:0] CFG_NET_ADDR  = 2'd0;
	localparam logic [1:0] CFG_NET_MASK  = 2'd1;
	localparam logic [1:0] CFG_FLUSH_IVL = 2'd2;

	typedef struct packed {
		logic        operation;
		logic [15:0] frame_type;
		logic [7:0]  ip_protocol;
		logic [31:0] src_ip;
		logic [31:0] dst_ip;
		logic [15:0] frame_length;
	} lfrb_hdr_t;

	typedef struct packed {
		logic        incoming;
		logic [31:0] host_bits;
		logic [1:0]  traffic_kind;
		logic [15:0] byte_count;
	} lfrb_rec_t;

	localparam int REC_W = $bits(lfrb_rec_t);

	typedef struct packed {
		logic        incoming;
		logic [31:0] host_bits;
		logic [1:0]  traffic_kind;
		logic [15:0] byte_count;
		logic        last_of_batch;
	} lfrb_out_t;

	typedef struct packed {
		logic issue;
		logic last;
	} lfrb_rd_t;

	typedef enum logic {
		ST_IDLE,
		ST_FLUSH
	} lfrb_state_t;

endpackage

`default_nettype wire

// ===== src/local_flow_record_batcher.sv =====
// Top level of the local flow record batcher: config, timers, store, flush control.
// Depends on lfrb_pkg, lfrb_ram, lfrb_classify and lfrb_emit.
//
//  channel  direction  handshake            payload
//  hdr      in         hdr_valid/hdr_stall  lfrb_hdr_t
//  rec      out        rec_valid/rec_stall  lfrb_out_t
//  cfg      in         cfg_valid/cfg_ready  cfg_index, cfg_data
//
// A tick or a packet that causes no flush is taken without a stall.
// A flush holds hdr_stall while the store is read, one record a cycle, with
// reads held back whenever rec_stall fills the two-entry output queue.
// The first record passes through ST_FLUSH, the store read register and main_q.
// The record store needs no clearing after reset; the block is ready at once.
`default_nettype none

module local_flow_record_batcher
	import lfrb_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        hdr_valid,
	output logic             hdr_stall,
	input  wire lfrb_hdr_t   hdr,
	output logic             rec_valid,
	input  wire logic        rec_stall,
	output lfrb_out_t        rec,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [31:0] cfg_data
);

	lfrb_state_t      state_q, state_d;
	logic [31:0]      net_addr_q;
	logic [31:0]      net_mask_q;
	logic [15:0]      flush_ivl_q;
	logic [31:0]      now_q;
	logic [31:0]      last_flush_q;
	logic [ADDR_W-1:0] rec_cnt_q;
	logic [ADDR_W-1:0] rd_idx_q;
	logic [ADDR_W-1:0] last_idx_q;

	logic             hdr_acc;
	logic             hit;
	lfrb_rec_t        new_rec;
	logic             pkt_wr;
	logic             full;
	logic             expired;
	logic             flush_go;
	logic             space;
	lfrb_rd_t         rd;
	logic [REC_W-1:0] rdata;

	assign cfg_ready = 1'b1;
	assign hdr_stall = (state_q != ST_IDLE);
	assign hdr_acc   = hdr_valid && !hdr_stall;
	assign pkt_wr    = hdr_acc && (hdr.operation == OP_PACKET) && hit;
	assign full      = (({1'b0, rec_cnt_q} + CNT_W'(1)) == CNT_W'(BATCH_DEPTH));
	assign expired   = ((now_q - last_flush_q) > {16'd0, flush_ivl_q});
	assign flush_go  = pkt_wr && (full || expired);

	lfrb_classify u_classify (
		.hdr      (hdr),
		.net_addr (net_addr_q),
		.net_mask (net_mask_q),
		.hit      (hit),
		.rec      (new_rec)
	);

	lfrb_ram #(
		.WIDTH (REC_W),
		.DEPTH (BATCH_DEPTH),
		.AW    (ADDR_W)
	) u_store (
		.clk   (clk),
		.we    (pkt_wr),
		.waddr (rec_cnt_q),
		.wdata (new_rec),
		.re    (rd.issue),
		.raddr (rd_idx_q),
		.rdata (rdata)
	);

	lfrb_emit u_emit (
		.clk       (clk),
		.arst_n    (arst_n),
		.rd        (rd),
		.rdata     (rdata),
		.space     (space),
		.rec_valid (rec_valid),
		.rec_stall (rec_stall),
		.rec       (rec)
	);

	always_comb begin
		state_d  = state_q;
		rd.issue = 1'b0;
		rd.last  = (rd_idx_q == last_idx_q);
		unique case (state_q)
			ST_IDLE: begin
				if (flush_go) begin
					state_d = ST_FLUSH;
				end
			end
			ST_FLUSH: begin
				rd.issue = space;
				if (space && rd.last) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			net_addr_q   <= '0;
			net_mask_q   <= '0;
			flush_ivl_q  <= FLUSH_IVL_RST;
			now_q        <= '0;
			last_flush_q <= '0;
			rec_cnt_q    <= '0;
			rd_idx_q     <= '0;
			last_idx_q   <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					CFG_NET_ADDR:  net_addr_q  <= cfg_data;
					CFG_NET_MASK:  net_mask_q  <= cfg_data;
					CFG_FLUSH_IVL: flush_ivl_q <= cfg_data[15:0];
					default: ;
				endcase
			end
			if (hdr_acc && (hdr.operation == OP_TICK)) begin
				now_q <= now_q + 32'd1;
			end
			if (flush_go) begin
				rec_cnt_q    <= '0;
				last_flush_q <= now_q;
				last_idx_q   <= rec_cnt_q;
				rd_idx_q     <= '0;
			end else if (pkt_wr) begin
				rec_cnt_q <= rec_cnt_q + ADDR_W'(1);
			end
			if (rd.issue) begin
				rd_idx_q <= rd_idx_q + ADDR_W'(1);
			end
		end
	end

	a_no_write_during_read: assert property (@(posedge clk) disable iff (!arst_n)
		pkt_wr |-> !rd.issue)
		else $error("record store written during readout");

	a_flush_clears_count: assert property (@(posedge clk) disable iff (!arst_n)
		flush_go |=> (rec_cnt_q == '0) && (state_q == ST_FLUSH))
		else $error("flush did not clear the record count");

	a_last_read_ends_flush: assert property (@(posedge clk) disable iff (!arst_n)
		(rd.issue && rd.last) |=> (state_q == ST_IDLE))
		else $error("readout did not end after the last record");

	a_read_only_in_flush: assert property (@(posedge clk) disable iff (!arst_n)
		rd.issue |-> (state_q == ST_FLUSH) && space)
		else $error("store read issued without a free output slot");

endmodule

`default_nettype wire

// ===== src/lfrb_ram.sv =====
// Generic single-clock RAM, one write port and one registered read port.
// No dependencies.
`default_nettype none

module lfrb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

// ===== src/lfrb_classify.sv =====
// Classifies one packet header against the local subnet and builds its record.
// Depends on lfrb_pkg.
`default_nettype none

module lfrb_classify
	import lfrb_pkg::*;
(
	input  wire lfrb_hdr_t   hdr,
	input  wire logic [31:0] net_addr,
	input  wire logic [31:0] net_mask,
	output logic             hit,
	output lfrb_rec_t        rec
);

	logic is_ipv4;
	logic src_local;
	logic dst_local;

	assign is_ipv4   = (hdr.frame_type == ETHER_IPV4);
	assign src_local = ((hdr.src_ip & net_mask) == net_addr);
	assign dst_local = ((hdr.dst_ip & net_mask) == net_addr);
	assign hit       = is_ipv4 && (src_local || dst_local);

	always_comb begin
		rec.incoming   = !src_local;
		rec.host_bits  = src_local ? (hdr.src_ip & ~net_mask) : (hdr.dst_ip & ~net_mask);
		rec.byte_count = hdr.frame_length;
		priority if (hdr.ip_protocol == PROTO_TCP) begin
			rec.traffic_kind = KIND_TCP;
		end else if (hdr.ip_protocol == PROTO_UDP) begin
			rec.traffic_kind = KIND_UDP;
		end else begin
			rec.traffic_kind = KIND_OTHER;
		end
	end

endmodule

`default_nettype wire

// ===== src/lfrb_emit.sv =====
// Output queue of two entries fed by the record store read port.
// Depends on lfrb_pkg; grants reads only when a slot is sure to be free.
`default_nettype none

module lfrb_emit
	import lfrb_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire lfrb_rd_t         rd,
	input  wire logic [REC_W-1:0] rdata,
	output logic                  space,
	output logic                  rec_valid,
	input  wire logic             rec_stall,
	output lfrb_out_t             rec
);

	logic      inflight_s1;
	logic      last_s1;
	logic      main_v_q;
	logic      skid_v_q;
	lfrb_out_t main_q;
	lfrb_out_t skid_q;
	lfrb_out_t arr;
	logic      pop;
	logic [1:0] occ;

	assign arr       = {rdata, last_s1};
	assign pop       = main_v_q && !rec_stall;
	assign occ       = {1'b0, main_v_q} + {1'b0, skid_v_q} + {1'b0, inflight_s1};
	assign space     = (occ < 2'd2) || ((occ == 2'd2) && pop);
	assign rec_valid = main_v_q;
	assign rec       = main_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inflight_s1 <= 1'b0;
			main_v_q    <= 1'b0;
			skid_v_q    <= 1'b0;
		end else begin
			inflight_s1 <= rd.issue;
			if (main_v_q && !pop) begin
				if (!skid_v_q && inflight_s1) begin
					skid_v_q <= 1'b1;
				end
			end else if (skid_v_q) begin
				main_v_q <= 1'b1;
				skid_v_q <= inflight_s1;
			end else begin
				main_v_q <= inflight_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		last_s1 <= rd.last;
		if (main_v_q && !pop) begin
			if (!skid_v_q) begin
				skid_q <= arr;
			end
		end else if (skid_v_q) begin
			main_q <= skid_q;
			skid_q <= arr;
		end else begin
			main_q <= arr;
		end
	end

endmodule

`default_nettype wire
